/* rtl/core/feistel_32bit_codec_assert.svh */
// Assertion macros for the Feistel codec RTL.
// No dependencies; the user module must provide clk and rst_n.
`ifndef FEISTEL_32BIT_CODEC_ASSERT_SVH
`define FEISTEL_32BIT_CODEC_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FC32_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fc32 same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define FC32_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fc32 next-cycle check failed");

`endif

/* rtl/core/fc32_pkg.sv */
// Shared constants, types and round-function helpers for the Feistel codec.
// No dependencies.
package fc32_pkg;

    localparam int WORD_W    = 32;
    localparam int HALF_W    = WORD_W / 2;
    localparam int ROUNDS    = 4;          // 1 to 4
    localparam int KEY_COUNT = 4;
    localparam int KEY_IDX_W = $clog2(KEY_COUNT);
    localparam int ADDR_W    = KEY_IDX_W + 2;
    localparam int ROT_L     = 5;
    localparam int SHR_F     = 11;

    // request codes
    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    localparam logic [WORD_W-1:0] KEY_RESET = WORD_W'(1);

    // beat handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic              dec;
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
    } beat_t;

    // first half of the round function: key xor, odd add, rotate xor
    function automatic logic [WORD_W-1:0] fc32_mix(input logic [HALF_W-1:0] h,
                                                   input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] odd;
        x   = {{(WORD_W-HALF_W){1'b0}}, h} ^ k;
        odd = {k[WORD_W-1:1], 1'b1};
        return (x + odd) ^ {x[WORD_W-1-ROT_L:0], x[WORD_W-1:WORD_W-ROT_L]};
    endfunction

    // second half: fold the wrapped product and keep the low half
    function automatic logic [HALF_W-1:0] fc32_fold(input logic [WORD_W-1:0] p);
        return p[HALF_W-1:0] ^ p[HALF_W-1+SHR_F:SHR_F];
    endfunction

endpackage

/* rtl/core/fc32_if.sv */
// Valid/ready channel interfaces for the Feistel codec.
// Depends on fc32_pkg.
interface fc32_req_if
    import fc32_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [WORD_W-1:0] data_word;

    modport source (output valid, req_type, data_word, input ready);
    modport sink   (input valid, req_type, data_word, output ready);
endinterface

interface fc32_res_if
    import fc32_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] coded_word;

    modport source (output valid, coded_word, input ready);
    modport sink   (input valid, coded_word, output ready);
endinterface

/* rtl/core/fc32_cell.sv */
// One Feistel round as a two-stage cell: mix stage, then multiply and fold.
// Depends on fc32_pkg.
module fc32_cell
    import fc32_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WORD_W-1:0] key_enc,
    input  logic [WORD_W-1:0] key_dec,
    input  beat_t             up,
    output logic              up_ready,
    output beat_t             dn,
    input  logic              dn_ready
);

    logic              s1_vld_reg, s1_vld_next;
    logic              s1_dec_reg, s1_dec_next;
    logic [HALF_W-1:0] s1_hi_reg,  s1_hi_next;
    logic [HALF_W-1:0] s1_lo_reg,  s1_lo_next;
    logic [WORD_W-1:0] s1_mix_reg, s1_mix_next;
    logic [WORD_W-1:0] s1_odd_reg, s1_odd_next;

    logic              s2_vld_reg, s2_vld_next;
    logic              s2_dec_reg, s2_dec_next;
    logic [HALF_W-1:0] s2_hi_reg,  s2_hi_next;
    logic [HALF_W-1:0] s2_lo_reg,  s2_lo_next;

    logic              s1_ready;
    logic              s2_ready;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] prod;

    assign s2_ready = !s2_vld_reg || dn_ready;
    assign s1_ready = !s1_vld_reg || s2_ready;
    assign up_ready = s1_ready;

    assign key  = (up.dec == REQ_DECODE) ? key_dec : key_enc;
    assign prod = s1_mix_reg * s1_odd_reg;   // low 32 bits of the product

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        s1_dec_next = s1_dec_reg;
        s1_hi_next  = s1_hi_reg;
        s1_lo_next  = s1_lo_reg;
        s1_mix_next = s1_mix_reg;
        s1_odd_next = s1_odd_reg;
        if (s1_ready)
        begin
            s1_vld_next = up.vld;
            s1_dec_next = up.dec;
            s1_hi_next  = up.hi;
            s1_lo_next  = up.lo;
            s1_mix_next = fc32_mix(up.lo, key);
            s1_odd_next = {key[WORD_W-1:1], 1'b1};
        end
    end

    always_comb
    begin
        s2_vld_next = s2_vld_reg;
        s2_dec_next = s2_dec_reg;
        s2_hi_next  = s2_hi_reg;
        s2_lo_next  = s2_lo_reg;
        if (s2_ready)
        begin
            s2_vld_next = s1_vld_reg;
            s2_dec_next = s1_dec_reg;
            s2_hi_next  = s1_lo_reg;
            s2_lo_next  = s1_hi_reg ^ fc32_fold(prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dec_reg <= s1_dec_next;
        s1_hi_reg  <= s1_hi_next;
        s1_lo_reg  <= s1_lo_next;
        s1_mix_reg <= s1_mix_next;
        s1_odd_reg <= s1_odd_next;
        s2_dec_reg <= s2_dec_next;
        s2_hi_reg  <= s2_hi_next;
        s2_lo_reg  <= s2_lo_next;
    end

    assign dn.vld = s2_vld_reg;
    assign dn.dec = s2_dec_reg;
    assign dn.hi  = s2_hi_reg;
    assign dn.lo  = s2_lo_reg;

endmodule

/* rtl/core/feistel_32bit_codec.sv */
// Top level of the Feistel codec: APB key registers and a chain of round cells.
// Depends on fc32_pkg, fc32_if, fc32_cell and feistel_32bit_codec_assert.svh.
//
//  channel   dir  handshake     beat contents
//  req_ch    in   valid/ready   req_type (0 encode, 1 decode), data_word[31:0]
//  res_ch    out  valid/ready   coded_word[31:0]
//  apb       in   psel/penable  round_key_0..3 at byte addresses 0, 4, 8, 12
//
// Every round cell holds a mix stage and a multiply stage. One beat is taken per
// cycle while the output side keeps up. Reset clears all stage valid bits and
// sets every key to 1. A stall on res_ch backs up stage by stage; bubbles in the
// chain still close up, so req_ch stays ready until the chain is actually full.
`include "feistel_32bit_codec_assert.svh"

module feistel_32bit_codec
    import fc32_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready,
    // data channels
    fc32_req_if.sink          req_ch,
    fc32_res_if.source        res_ch
);

    // ---- key registers ----
    logic [WORD_W-1:0]    key_reg  [KEY_COUNT];
    logic [WORD_W-1:0]    key_next [KEY_COUNT];
    logic                 wr_en;
    logic [KEY_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];     // byte offset bits are don't-care
    assign prdata  = key_reg[reg_idx];

    always_comb
    begin
        key_next = key_reg;
        if (wr_en)
        begin
            key_next[reg_idx] = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                key_reg[i] <= KEY_RESET;
            end
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // ---- round chain ----
    // Decode is the encode round run on swapped halves with the keys reversed,
    // so one cell type serves both: swap on entry, swap back on exit.
    beat_t link [ROUNDS+1];
    logic  rdy  [ROUNDS+1];

    assign link[0].vld = req_ch.valid;
    assign link[0].dec = req_ch.req_type;
    assign link[0].hi  = (req_ch.req_type == REQ_DECODE) ?
                         req_ch.data_word[HALF_W-1:0] : req_ch.data_word[WORD_W-1:HALF_W];
    assign link[0].lo  = (req_ch.req_type == REQ_DECODE) ?
                         req_ch.data_word[WORD_W-1:HALF_W] : req_ch.data_word[HALF_W-1:0];
    assign req_ch.ready = rdy[0];

    for (genvar g = 0; g < ROUNDS; g++)
    begin : g_round
        fc32_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .key_enc  (key_reg[g]),
            .key_dec  (key_reg[ROUNDS-1-g]),
            .up       (link[g]),
            .up_ready (rdy[g]),
            .dn       (link[g+1]),
            .dn_ready (rdy[g+1])
        );
    end

    // last cell's second stage is the output register
    assign rdy[ROUNDS]       = res_ch.ready;
    assign res_ch.valid      = link[ROUNDS].vld;
    assign res_ch.coded_word = (link[ROUNDS].dec == REQ_DECODE) ?
                               {link[ROUNDS].lo, link[ROUNDS].hi} :
                               {link[ROUNDS].hi, link[ROUNDS].lo};

    // ---- checks ----
    // an empty output stage means the whole chain can move, so input is open
    `FC32_ASSERT_NOW(a_ready_when_drained, !res_ch.valid, req_ch.ready)
    // a key write lands in the addressed register
    `FC32_ASSERT_NEXT(a_key_write, wr_en, key_reg[$past(reg_idx)] == $past(pwdata))
    // a full last cell whose output is not taken stalls its own input
    `FC32_ASSERT_NOW(a_full_stall, res_ch.valid && !res_ch.ready && link[ROUNDS-1].vld &&
                     g_round[ROUNDS-1].u_cell.s1_vld_reg == 1'b1, !rdy[ROUNDS-1])

endmodule

/* tb/feistel_32bit_codec_checker.sv */
// Result checker for the Feistel codec: watches request, result and APB traffic.
// Depends on fc32_pkg and the channel interfaces in fc32_if.
module feistel_32bit_codec_checker
    import fc32_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    fc32_req_if               req_mon,
    fc32_res_if               res_mon,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output int                words_in_flight,
    output int                mismatches
);

    // out-of-range round counts clamp to 0..KEY_COUNT
    localparam int ACTIVE_ROUNDS = (ROUNDS < 0) ? 0 :
                                   (ROUNDS > KEY_COUNT) ? KEY_COUNT : ROUNDS;

    logic [WORD_W-1:0] round_keys [KEY_COUNT];
    logic [WORD_W-1:0] predicted_words [$];

    // round function; the xor uses the key as written, add and multiply the odd key
    function automatic logic [HALF_W-1:0] round_scramble(input logic [HALF_W-1:0] half,
                                                         input logic [WORD_W-1:0] key);
        logic [WORD_W-1:0] odd_key;
        logic [WORD_W-1:0] mixed;
        logic [WORD_W-1:0] prod;
        odd_key = key | 32'd1;
        mixed   = {16'h0000, half} ^ key;
        mixed   = (mixed + odd_key) ^ ((mixed << 5) | (mixed >> 27));
        prod    = mixed * odd_key;
        prod    = prod ^ (prod >> 11);
        return prod[HALF_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] feistel_transform(input logic op,
                                                            input logic [WORD_W-1:0] word);
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] nxt;
        int                r;
        hi = word[WORD_W-1:HALF_W];
        lo = word[HALF_W-1:0];
        if (op == REQ_DECODE)
        begin
            for (r = ACTIVE_ROUNDS; r > 0; r--)
            begin
                nxt = lo ^ round_scramble(hi, round_keys[r-1]);
                lo  = hi;
                hi  = nxt;
            end
        end
        else
        begin
            for (r = 0; r < ACTIVE_ROUNDS; r++)
            begin
                nxt = hi ^ round_scramble(lo, round_keys[r]);
                hi  = lo;
                lo  = nxt;
            end
        end
        return {hi, lo};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [WORD_W-1:0] want;
        if (!rst_n)
        begin
            round_keys      <= '{default: KEY_RESET};
            predicted_words.delete();
            words_in_flight <= 0;
            mismatches      <= 0;
        end
        else
        begin
            if (res_mon.valid && res_mon.ready)
            begin
                if (predicted_words.size() == 0)
                begin
                    $error("coded_word: expected none, actual %h", res_mon.coded_word);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = predicted_words.pop_front();
                    if (res_mon.coded_word !== want)
                    begin
                        $error("coded_word: expected %h, actual %h", want, res_mon.coded_word);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
                predicted_words.insert(predicted_words.size(),
                                       feistel_transform(req_mon.req_type,
                                                         req_mon.data_word));
            // key writes must land only while idle (unenforced), so old keys hold
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] < KEY_COUNT)
                round_keys[paddr[ADDR_W-1:2]] <= pwdata;
            words_in_flight <= predicted_words.size();
        end
    end

endmodule

/* tb/feistel_32bit_codec_test.sv */
// Top of the Feistel codec regression: clock, reset, APB key writes and beat traffic.
// Depends on fc32_pkg, fc32_if, feistel_32bit_codec and feistel_32bit_codec_checker.
module feistel_32bit_codec_test;
    import fc32_pkg::*;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int LONG_STALL      = 80;    // well past what the 8-stage chain can absorb
    localparam int SETTLE_CYCLES   = 2 * ROUNDS + 4;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [WORD_W-1:0] pwdata;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    int words_in_flight;
    int mismatches;

    // idle rates in percent per beat, changed per phase
    int offer_gap_pct = 0;
    int take_stall_pct = 0;
    // raised by the stimulus, cleared by the receiver once its long hold is over
    bit hold_results = 1'b0;

    fc32_req_if req_ch ();
    fc32_res_if res_ch ();

    feistel_32bit_codec dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req_ch  (req_ch),
        .res_ch  (res_ch)
    );

    feistel_32bit_codec_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_mon         (req_ch),
        .res_mon         (res_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .words_in_flight (words_in_flight),
        .mismatches      (mismatches)
    );

    always #5 clk = ~clk;

    // Hard stop; the slowest legal run is far shorter than this.
    initial
    begin
        #2000000;
        $display("feistel_32bit_codec regression: fail");
        $finish;
    end

    // Offer one beat and hold it until taken. Called at a rising edge; returns
    // at the edge where the beat went in, with valid still high so the next
    // beat can follow back to back.
    task automatic offer_word(input logic op, input logic [WORD_W-1:0] word);
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.data_word <= word;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Stop offering and wait until every predicted word has come back.
    // The first edge is taken before looking, so a beat accepted at the
    // calling edge is already counted.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (words_in_flight != 0);
    endtask

    // APB setup + access. psel is left high so writes chain without a
    // second assignment in one step; the caller drops it after the last one.
    task automatic write_key(input int idx, input logic [WORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    // Key sets per phase: all zero and all ones are the extremes, phase 3
    // uses even keys (the odd-forcing only applies to add and multiply),
    // phase 4 sits on the sign boundary.
    function automatic logic [WORD_W-1:0] phase_key(input int phase, input int idx);
        case (phase)
            1: return '0;
            2: return '1;
            3: return $urandom & ~32'd1;
            4: return idx[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly random words, with some halves pinned to all zero / all ones.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return {16'h0000, 16'($urandom)};
            1: return {16'hFFFF, 16'($urandom)};
            2: return {16'($urandom), 16'h0000};
            3: return {16'($urandom), 16'hFFFF};
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stall bursts, or one long hold on request.
    initial
    begin
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                // back the chain up until the request side stalls too
                res_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                hold_results = 1'b0;
                res_ch.ready <= 1'b1;
            end
            else if (take_stall_pct != 0 && $urandom_range(0, 99) < take_stall_pct)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Main stimulus.
    initial
    begin
        logic [WORD_W-1:0] probe_words [8];
        int                phase;
        int                n;
        int                k;

        probe_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000,
                        32'h8000_0000, 32'h0000_0001, 32'h1234_5678, 32'hA5A5_A5A5};

        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_ENCODE;
        req_ch.data_word <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes both ways, on the reset keys.
        foreach (probe_words[i])
        begin
            offer_word(REQ_ENCODE, probe_words[i]);
            offer_word(REQ_DECODE, probe_words[i]);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            // Phase 0 runs on the reset keys; later phases reload all four
            // while the chain is empty.
            if (phase > 0)
            begin
                drain_results();
                for (k = 0; k < KEY_COUNT; k++)
                    write_key(k, phase_key(phase, k));
                psel    <= 1'b0;
                penable <= 1'b0;
                pwrite  <= 1'b0;
            end

            // Phase 1 runs flat out; the last phase is the idle-free tail.
            case (phase)
                0: begin offer_gap_pct = 20; take_stall_pct = 20; end
                1: begin offer_gap_pct = 0;  take_stall_pct = 0;  end
                2: begin offer_gap_pct = 10; take_stall_pct = 30; end
                3: begin offer_gap_pct = 40; take_stall_pct = 10; end
                4: begin offer_gap_pct = 25; take_stall_pct = 25; end
                5: begin offer_gap_pct = 15; take_stall_pct = 40; end
                default: begin offer_gap_pct = 0; take_stall_pct = 0; end
            endcase

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long result-side hold while beats keep coming
                if (phase == 2 && n == 40)
                    hold_results = 1'b1;
                // sender pauses mid-phase until everything is back
                if (phase == 4 && n == ITEMS_PER_PHASE / 2)
                    drain_results();
                if (offer_gap_pct != 0 && $urandom_range(0, 99) < offer_gap_pct)
                begin
                    req_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 7)) @(posedge clk);
                end
                offer_word($urandom_range(0, 1) ? REQ_DECODE : REQ_ENCODE, pick_word());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && words_in_flight == 0)
            $display("feistel_32bit_codec regression: pass");
        else
            $display("feistel_32bit_codec regression: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/fc32_pkg.sv
rtl/core/fc32_if.sv
rtl/core/fc32_cell.sv
rtl/core/feistel_32bit_codec.sv
tb/feistel_32bit_codec_checker.sv
tb/feistel_32bit_codec_test.sv
